>>> sv/llt_pkg.sv
// package for the logic language tokenizer: types, kind codes, character tables
`default_nettype none
package llt_pkg;

  localparam int LenBits = 16;
  localparam int PosBits = 16;
  localparam int OffBits = 32;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         token_kind;
    logic [LenBits-1:0] text_length;
    logic [PosBits-1:0] end_line;
    logic [PosBits-1:0] end_column;
    logic [OffBits-1:0] end_offset;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_DEC, M_STR, M_OP, M_SLASH, M_COMMENT
  } mode_t;

  localparam logic [5:0] K_IDENT   = 6'd0;
  localparam logic [5:0] K_INT     = 6'd1;
  localparam logic [5:0] K_DEC     = 6'd2;
  localparam logic [5:0] K_STR     = 6'd3;
  localparam logic [5:0] K_KW0     = 6'd4;
  localparam logic [5:0] K_PAIR0   = 6'd11;
  localparam logic [5:0] K_SINGLE0 = 6'd19;
  localparam logic [5:0] K_DOT     = 6'd29;
  localparam logic [5:0] K_NEWLINE = 6'd33;
  localparam logic [5:0] K_EOF     = 6'd34;
  localparam logic [5:0] K_BAD     = 6'd35;
  localparam logic [5:0] K_UNTERM  = 6'd36;

  typedef struct packed {
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] col;
    logic [OffBits-1:0] off;
  } place_t;

  typedef struct packed {
    logic [5:0]         kind;
    logic [LenBits-1:0] len;
    place_t             at;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h5f;
  endfunction

  function automatic logic starts_pair(input logic [7:0] c);
    return c == ":" || c == "?" || c == "-" || c == "\\" || c == "<" || c == ">" ||
           c == "=" || c == "!";
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "=":     k = K_SINGLE0 + 6'd0;
      "<":     k = K_SINGLE0 + 6'd1;
      ">":     k = K_SINGLE0 + 6'd2;
      "|":     k = K_SINGLE0 + 6'd3;
      "(":     k = K_SINGLE0 + 6'd4;
      ")":     k = K_SINGLE0 + 6'd5;
      "{":     k = K_SINGLE0 + 6'd6;
      "}":     k = K_SINGLE0 + 6'd7;
      "[":     k = K_SINGLE0 + 6'd8;
      "]":     k = K_SINGLE0 + 6'd9;
      ".":     k = K_SINGLE0 + 6'd10;
      ",":     k = K_SINGLE0 + 6'd11;
      ";":     k = K_SINGLE0 + 6'd12;
      ":":     k = K_SINGLE0 + 6'd13;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

  // pair index 0..7, 8 when no pair
  function automatic logic [3:0] pair_index(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] r;
    r = 4'd8;
    if (a == ":" && b == "-") r = 4'd0;
    else if (a == "?" && b == "-") r = 4'd1;
    else if (a == "-" && b == ">") r = 4'd2;
    else if (a == "\\" && b == "=") r = 4'd3;
    else if (a == "<" && b == "=") r = 4'd4;
    else if (a == ">" && b == "=") r = 4'd5;
    else if (a == "=" && b == "=") r = 4'd6;
    else if (a == "!" && b == "=") r = 4'd7;
    return r;
  endfunction

  function automatic logic [5:0] word_kind(input logic [LenBits-1:0] n,
                                           input logic [39:0] p);
    logic [5:0] k;
    k = K_IDENT;
    if (n == LenBits'(4) && p == 40'h0066616374) k = K_KW0 + 6'd0;
    if (n == LenBits'(4) && p == 40'h0072756c65) k = K_KW0 + 6'd1;
    if (n == LenBits'(4) && p == 40'h0074797065) k = K_KW0 + 6'd2;
    if (n == LenBits'(2) && p == 40'h000000666e) k = K_KW0 + 6'd3;
    if (n == LenBits'(5) && p == 40'h6d61746368) k = K_KW0 + 6'd4;
    if (n == LenBits'(5) && p == 40'h7768657265) k = K_KW0 + 6'd5;
    if (n == LenBits'(3) && p == 40'h00006c6574) k = K_KW0 + 6'd6;
    return k;
  endfunction

  function automatic logic [LenBits-1:0] len_inc(input logic [LenBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [PosBits-1:0] pos_inc(input logic [PosBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

>>> sv/logic_language_tokenizer.sv
// top level of the logic language tokenizer
//
//  channel | signals                         | dir | payload
//  in      | in_valid, in_stall, in_data     | in  | llt_pkg::in_item_t
//  out     | out_valid, out_stall, out_data  | out | llt_pkg::out_item_t, up to 3 per input
//
// one byte per unstalled cycle: the scanner state and up to three tokens are computed in
// one pass and written into a three-entry token buffer, drained one token per unstalled cycle
// in_stall is high while the buffer holds more than one token, or holds one while
// out_stall is high, so a byte with several tokens holds the next until its last one leaves
// reset restores the idle scanner, line and column 1, offset 0, empty buffer
`default_nettype none
module logic_language_tokenizer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire llt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output llt_pkg::out_item_t      out_data
);
  import llt_pkg::*;

  mode_t              mode, mode_next;
  logic [7:0]         held_op, held_op_next;
  logic               esc, esc_next;
  logic [LenBits-1:0] run_len, run_len_next;
  logic [39:0]        prefix, prefix_next;
  place_t             pos, pos_next;
  place_t             held_pos, held_pos_next;

  tok_t       buf_tok [3];
  logic [1:0] buf_cnt;
  logic [1:0] buf_rd;

  tok_t       emit_tok [3];
  logic [1:0] emit_n;

  logic       accept;
  logic       pop;
  logic [7:0] c;
  place_t     prev, now;

  assign pop      = out_valid && !out_stall;
  assign in_stall = (buf_cnt > 2'd1) || (buf_cnt == 2'd1 && out_stall);
  assign accept   = in_valid && !in_stall;
  assign c        = in_data.source_byte;

  always_comb begin
    logic        st;
    logic [5:0]  sk;
    prev = pos;
    now  = pos;
    if (c == 8'h0a) begin
      now.line = pos_inc(pos.line);
      now.col  = PosBits'(1);
    end else begin
      now.col = pos_inc(pos.col);
    end
    now.off = pos.off + 1'b1;

    mode_next     = mode;
    held_op_next  = held_op;
    esc_next      = esc;
    run_len_next  = run_len;
    prefix_next   = prefix;
    pos_next      = pos;
    held_pos_next = held_pos;
    emit_n        = 2'd0;
    for (int i = 0; i < 3; i++) emit_tok[i] = '0;
    st = 1'b0;
    sk = single_kind(held_op);

    if (in_data.is_end) begin
      unique case (mode)
        M_IDENT: begin
          emit_tok[0] = '{word_kind(run_len, prefix), run_len, pos}; emit_n = 2'd1;
        end
        M_INT: begin
          emit_tok[0] = '{K_INT, run_len, pos}; emit_n = 2'd1;
        end
        M_INT_DOT: begin
          emit_tok[0] = '{K_INT, run_len, held_pos};
          emit_tok[1] = '{K_DOT, LenBits'(1), pos};
          emit_n = 2'd2;
        end
        M_DEC: begin
          emit_tok[0] = '{K_DEC, run_len, pos}; emit_n = 2'd1;
        end
        M_STR: begin
          emit_tok[0] = '{K_UNTERM, run_len, pos}; emit_n = 2'd1;
        end
        M_OP: begin
          emit_tok[0] = '{sk, LenBits'(1), pos}; emit_n = 2'd1;
        end
        M_SLASH: begin
          emit_tok[0] = '{K_BAD, LenBits'(1), pos}; emit_n = 2'd1;
        end
        default: ;
      endcase
      emit_tok[emit_n] = '{K_EOF, LenBits'(0), pos};
      emit_n = emit_n + 2'd1;
      mode_next     = M_IDLE;
      held_op_next  = '0;
      esc_next      = 1'b0;
      run_len_next  = '0;
      prefix_next   = '0;
      pos_next      = '{PosBits'(1), PosBits'(1), OffBits'(0)};
      held_pos_next = '{PosBits'(1), PosBits'(1), OffBits'(0)};
    end else begin
      pos_next = now;
      unique case (mode)
        M_IDENT: begin
          if (is_word(c)) begin
            if (run_len < LenBits'(5)) prefix_next = {prefix[31:0], c};
            run_len_next = len_inc(run_len);
          end else begin
            emit_tok[0] = '{word_kind(run_len, prefix), run_len, prev};
            emit_n = 2'd1; st = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) run_len_next = len_inc(run_len);
          else if (c == ".") begin
            held_pos_next = prev; mode_next = M_INT_DOT;
          end else begin
            emit_tok[0] = '{K_INT, run_len, prev}; emit_n = 2'd1; st = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(c)) begin
            run_len_next = len_inc(len_inc(run_len)); mode_next = M_DEC;
          end else begin
            emit_tok[0] = '{K_INT, run_len, held_pos};
            emit_tok[1] = '{K_DOT, LenBits'(1), prev};
            emit_n = 2'd2; st = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit(c)) run_len_next = len_inc(run_len);
          else begin
            emit_tok[0] = '{K_DEC, run_len, prev}; emit_n = 2'd1; st = 1'b1;
          end
        end
        M_STR: begin
          if (esc) begin
            run_len_next = len_inc(run_len); esc_next = 1'b0;
          end else if (c == 8'h22) begin
            emit_tok[0] = '{K_STR, run_len, now}; emit_n = 2'd1; mode_next = M_IDLE;
          end else begin
            run_len_next = len_inc(run_len); esc_next = (c == 8'h5c);
          end
        end
        M_OP: begin
          if (pair_index(held_op, c) != 4'd8) begin
            emit_tok[0] = '{K_PAIR0 + 6'(pair_index(held_op, c)), LenBits'(2), now};
            emit_n = 2'd1; mode_next = M_IDLE;
          end else begin
            emit_tok[0] = '{sk, LenBits'(1), prev}; emit_n = 2'd1; st = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_next = M_COMMENT;
          else begin
            emit_tok[0] = '{K_BAD, LenBits'(1), prev}; emit_n = 2'd1; st = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0a) st = 1'b1;
        end
        default: st = 1'b1;
      endcase
      if (st) begin
        mode_next = M_IDLE;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0d) begin
        end else if (c == 8'h0a) begin
          emit_tok[emit_n] = '{K_NEWLINE, LenBits'(1), now}; emit_n = emit_n + 2'd1;
        end else if (c == "/") begin
          mode_next = M_SLASH;
        end else if (is_alpha(c) || c == 8'h5f) begin
          mode_next = M_IDENT; run_len_next = LenBits'(1); prefix_next = {32'd0, c};
        end else if (is_digit(c)) begin
          mode_next = M_INT; run_len_next = LenBits'(1);
        end else if (c == 8'h22) begin
          mode_next = M_STR; run_len_next = '0; esc_next = 1'b0;
        end else if (starts_pair(c)) begin
          mode_next = M_OP; held_op_next = c;
        end else begin
          emit_tok[emit_n] = '{single_kind(c), LenBits'(1), now}; emit_n = emit_n + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      held_op  <= '0;
      esc      <= 1'b0;
      run_len  <= '0;
      prefix   <= '0;
      pos      <= '{PosBits'(1), PosBits'(1), OffBits'(0)};
      held_pos <= '{PosBits'(1), PosBits'(1), OffBits'(0)};
      buf_cnt  <= 2'd0;
      buf_rd   <= 2'd0;
    end else begin
      if (accept) begin
        mode     <= mode_next;
        held_op  <= held_op_next;
        esc      <= esc_next;
        run_len  <= run_len_next;
        prefix   <= prefix_next;
        pos      <= pos_next;
        held_pos <= held_pos_next;
      end
      if (accept && emit_n != 2'd0) begin
        // buffer is empty or its last entry is leaving now
        buf_tok[0] <= emit_tok[0];
        buf_tok[1] <= emit_tok[1];
        buf_tok[2] <= emit_tok[2];
        buf_cnt    <= emit_n;
        buf_rd     <= 2'd0;
      end else if (pop) begin
        buf_cnt <= buf_cnt - 2'd1;
        buf_rd  <= buf_rd + 2'd1;
      end
    end
  end

  assign out_valid = buf_cnt != 2'd0;
  always_comb begin
    tok_t t;
    t = buf_tok[buf_rd];
    out_data.token_kind  = t.kind;
    out_data.text_length = t.len;
    out_data.end_line    = t.at.line;
    out_data.end_column  = t.at.col;
    out_data.end_offset  = t.at.off;
    out_data.last_of_run = (buf_cnt == 2'd1);
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    buf_cnt > 2'd1 |-> in_stall) else $error("input taken with tokens pending");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    buf_cnt != 2'd3 || buf_rd == 2'd0) else $error("read pointer off at full buffer");
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.is_end |=> mode == M_IDLE && pos.off == '0)
    else $error("end marker did not reset scanner");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == K_EOF |-> out_data.last_of_run)
    else $error("eof token not last");

endmodule
`default_nettype wire
